FILE: rtl/fixed_point_alu_macros.svh
// Assertion macros used by the checker file
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

// Implication checked at every clock edge outside reset
`define FPA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset
`define FPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/fpa_pkg.sv
// ---------------------------------------------------------------------------
// fpa_pkg
// Opcodes, payload types and pipeline control structs of the fixed-point ALU.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpa_pkg;

	localparam int WordW = 32;
	localparam int CmdW  = 4;

	typedef enum logic [CmdW-1:0] {
		CMD_ADD    = 4'd0,
		CMD_SUB    = 4'd1,
		CMD_MUL    = 4'd2,
		CMD_DIV    = 4'd3,
		CMD_CMP    = 4'd4,
		CMD_MIN    = 4'd5,
		CMD_MAX    = 4'd6,
		CMD_INC    = 4'd7,
		CMD_DEC    = 4'd8,
		CMD_I2F    = 4'd9,
		CMD_F2I    = 4'd10
	} cmd_t;

	// operation class decided by the front part
	typedef enum logic [1:0] {
		CLS_SIMPLE = 2'd0,
		CLS_MUL    = 2'd1,
		CLS_DIV    = 2'd2
	} cls_t;

	typedef struct packed {
		logic [CmdW-1:0]         cmd;
		logic signed [WordW-1:0] operand_a;
		logic signed [WordW-1:0] operand_b;
	} in_item_t;

	typedef struct packed {
		logic signed [WordW-1:0] result;
		logic less;
		logic equal;
		logic greater;
		logic overflow;
		logic div_by_zero;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		cls_t                    cls;
		logic                    neg;
		logic [WordW-1:0]        mag_a;
		logic [WordW-1:0]        mag_b;
		out_item_t               simple;
	} job_t;

endpackage

FILE: rtl/fpa_stream_if.sv
// ---------------------------------------------------------------------------
// fpa_stream_if
// Valid/ready channel carrying one payload word per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fpa_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/fixed_point_alu.sv
// ---------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU: front classifier, job queue and execution pipeline.
//
//   channel | dir | payload
//   in_ch   | in  | cmd, operand_a, operand_b
//   out_ch  | out | result, less, equal, greater, overflow, div_by_zero
//
// One transaction per cycle is accepted and delivered when out_ch is ready.
// Every operation passes through the same stages: the divider retires one
// quotient bit per stage and all operations share its depth.
// arst_n clears all valid flags; payload registers are not reset.
// A stall on out_ch freezes the back pipeline; the queue then fills and
// in_ch ready falls after it is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_point_alu #(
	parameter int FRACTION_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	fpa_stream_if.sink   in_ch,
	fpa_stream_if.source out_ch
);
	import fpa_pkg::*;

	job_t fr_data, bk_data;
	logic fr_valid, fr_ready, bk_valid, bk_ready;

	fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
		.clk, .arst_n,
		.in_data  (in_ch.data),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.job_data (fr_data),
		.job_valid(fr_valid),
		.job_ready(fr_ready)
	);

	fpa_queue #(.DEPTH(4)) u_queue (
		.clk, .arst_n,
		.wr_data (fr_data),
		.wr_valid(fr_valid),
		.wr_ready(fr_ready),
		.rd_data (bk_data),
		.rd_valid(bk_valid),
		.rd_ready(bk_ready)
	);

	fpa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
		.clk, .arst_n,
		.job_data (bk_data),
		.job_valid(bk_valid),
		.job_ready(bk_ready),
		.out_data (out_ch.data),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready)
	);

endmodule

FILE: rtl/fpa_front.sv
// ---------------------------------------------------------------------------
// fpa_front
// Accept transactions, compare operands, evaluate the simple operations and
// classify multiply and divide for the back part.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_front #(
	parameter int FRACTION_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fpa_pkg::in_item_t    in_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	output fpa_pkg::job_t        job_data,
	output logic                 job_valid,
	input  logic                 job_ready
);
	import fpa_pkg::*;

	logic signed [WordW-1:0] a, b;
	logic signed [WordW:0]   sum;
	logic signed [WordW:0]   dif;
	logic signed [WordW:0]   inc;
	logic signed [WordW:0]   dec;
	logic signed [WordW+FRACTION_BITS-1:0] shl;
	logic                    lt, eq;
	job_t                    job;
	job_t                    job_s1;
	logic                    vld_s1;

	assign a   = in_data.operand_a;
	assign b   = in_data.operand_b;
	assign lt  = a < b;
	assign eq  = a == b;
	assign sum = {a[WordW-1], a} + {b[WordW-1], b};
	assign dif = {a[WordW-1], a} - {b[WordW-1], b};
	assign inc = {a[WordW-1], a} + (WordW+1)'(1);
	assign dec = {a[WordW-1], a} - (WordW+1)'(1);
	assign shl = {{FRACTION_BITS{a[WordW-1]}}, a} <<< FRACTION_BITS;

	// classify and evaluate the simple operations
	always_comb begin
		job                    = '0;
		job.cls                = CLS_SIMPLE;
		job.neg                = a[WordW-1] ^ b[WordW-1];
		job.mag_a              = a[WordW-1] ? WordW'(-a) : WordW'(a);
		job.mag_b              = b[WordW-1] ? WordW'(-b) : WordW'(b);
		job.simple.less        = lt;
		job.simple.equal       = eq;
		job.simple.greater     = !lt && !eq;
		case (in_data.cmd)
			CMD_ADD: begin
				job.simple.result   = sum[WordW-1:0];
				job.simple.overflow = sum[WordW] != sum[WordW-1];
			end
			CMD_SUB: begin
				job.simple.result   = dif[WordW-1:0];
				job.simple.overflow = dif[WordW] != dif[WordW-1];
			end
			CMD_MUL: job.cls = CLS_MUL;
			CMD_DIV: begin
				if (b == '0) begin
					job.simple.div_by_zero = 1'b1;
				end else begin
					job.cls = CLS_DIV;
				end
			end
			CMD_MIN: job.simple.result = lt ? a : b;
			CMD_MAX: job.simple.result = (!lt && !eq) ? a : b;
			CMD_INC: begin
				job.simple.result   = inc[WordW-1:0];
				job.simple.overflow = inc[WordW] != inc[WordW-1];
			end
			CMD_DEC: begin
				job.simple.result   = dec[WordW-1:0];
				job.simple.overflow = dec[WordW] != dec[WordW-1];
			end
			CMD_I2F: begin
				job.simple.result   = shl[WordW-1:0];
				job.simple.overflow = shl != {{FRACTION_BITS{shl[WordW-1]}}, shl[WordW-1:0]};
			end
			CMD_F2I: job.simple.result = a >>> FRACTION_BITS;
			default: job.simple.result = '0;
		endcase
	end

	// hold one classified transaction until the queue takes it
	assign in_ready = !vld_s1 || job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			job_s1 <= job;
		end
	end

	assign job_data  = job_s1;
	assign job_valid = vld_s1;

endmodule

FILE: rtl/fpa_queue.sv
// ---------------------------------------------------------------------------
// fpa_queue
// Short first-in first-out queue decoupling the front part from the back part.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  fpa_pkg::job_t wr_data,
	input  logic          wr_valid,
	output logic          wr_ready,
	output fpa_pkg::job_t rd_data,
	output logic          rd_valid,
	input  logic          rd_ready
);
	import fpa_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PtrW:0]   cnt_q;
	logic            push, pop;

	assign wr_ready = cnt_q != (PtrW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	// store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end

endmodule

FILE: rtl/fpa_back.sv
// ---------------------------------------------------------------------------
// fpa_back
// Execute multiply and divide in a stalling pipeline: a 32x32 multiply in the
// capture stage and a radix-2 restoring divider with one stage per bit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_back #(
	parameter int FRACTION_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fpa_pkg::job_t     job_data,
	input  logic              job_valid,
	output logic              job_ready,
	output fpa_pkg::out_item_t out_data,
	output logic              out_valid,
	input  logic              out_ready
);
	import fpa_pkg::*;

	// quotient bits: magnitude of a shifted up, plus one guard bit for rounding
	localparam int NumW   = WordW + FRACTION_BITS;
	localparam int Stages = NumW + 1;
	localparam int LastS  = Stages + 1;

	typedef struct packed {
		job_t                  job;
		logic [NumW:0]         num;   // numerator shifted left by FRACTION_BITS plus one guard bit
		logic [WordW:0]        rem;
		logic [2*WordW-1:0]    prod;
	} stg_t;

	stg_t pipe_s [LastS+1];
	logic vld_s [LastS+1];
	logic adv;
	out_item_t res;
	logic [2*WordW-1:0] pm;
	logic [NumW:0]      q;
	logic [NumW:0]      qr;
	logic [2*WordW-1:0] pq;
	logic               ovf;
	logic [WordW-1:0]   rbits;

	// whole pipeline advances when the output register is free
	assign adv       = !out_valid || out_ready;
	assign job_ready = adv;

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LastS; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= job_valid;
			for (int i = 1; i <= LastS; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// payload: first stage captures, divider stages each retire one quotient bit
	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_s[0].job  <= job_data;
			pipe_s[0].num  <= {job_data.mag_a, {FRACTION_BITS{1'b0}}, 1'b0};
			pipe_s[0].rem  <= '0;
			pipe_s[0].prod <= job_data.mag_a * job_data.mag_b;
			for (int i = 1; i <= Stages; i++) begin
				logic [WordW+1:0] trial;
				logic [WordW:0]   sh;
				sh    = {pipe_s[i-1].rem[WordW-1:0], pipe_s[i-1].num[NumW]};
				trial = {1'b0, sh} - {2'b00, pipe_s[i-1].job.mag_b};
				pipe_s[i].job  <= pipe_s[i-1].job;
				pipe_s[i].prod <= pipe_s[i-1].prod;
				if (!trial[WordW+1]) begin
					pipe_s[i].rem <= trial[WordW:0];
					pipe_s[i].num <= {pipe_s[i-1].num[NumW-1:0], 1'b1};
				end else begin
					pipe_s[i].rem <= sh;
					pipe_s[i].num <= {pipe_s[i-1].num[NumW-1:0], 1'b0};
				end
			end
			pipe_s[LastS].job  <= pipe_s[Stages].job;
			pipe_s[LastS].num  <= pipe_s[Stages].num;
			pipe_s[LastS].rem  <= pipe_s[Stages].rem;
			pipe_s[LastS].prod <= pipe_s[Stages].prod;
		end
	end

	// final stage: round, scale and apply sign
	assign q  = pipe_s[LastS].num;
	// num holds quotient of (mag_a<<(F+1))/b; rounding: half up via guard bit
	assign qr = (q >> 1) + (NumW+1)'(q[0]);
	assign pm = pipe_s[LastS].prod >> FRACTION_BITS;
	assign pq = (pipe_s[LastS].job.cls == CLS_MUL) ? pm : (2*WordW)'(qr);

	always_comb begin
		if (pipe_s[LastS].job.neg) begin
			ovf   = pq > (2*WordW)'(33'h1_0000_0000 >> 1);
			rbits = WordW'(-pq);
		end else begin
			ovf   = pq > (2*WordW)'(32'h7fff_ffff);
			rbits = pq[WordW-1:0];
		end
		res = pipe_s[LastS].job.simple;
		if (pipe_s[LastS].job.cls != CLS_SIMPLE) begin
			res.result   = rbits;
			res.overflow = ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s[LastS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= res;
		end
	end

endmodule

FILE: rtl/fpa_checker.sv
// ---------------------------------------------------------------------------
// fpa_checker
// Port-level checks of the fixed-point ALU, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixed_point_alu_macros.svh"

module fpa_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input fpa_pkg::out_item_t out_data
);
	import fpa_pkg::*;

	// flags exclusive
	`FPA_ASSERT_IMPL(a_cmp_onehot, clk, arst_n, out_valid, $onehot({out_data.less, out_data.equal, out_data.greater}), "compare flags not one-hot")
	// divide by zero gives zero result without overflow
	`FPA_ASSERT_IMPL(a_dz_zero, clk, arst_n, out_valid && out_data.div_by_zero, out_data.result == '0 && !out_data.overflow, "divide by zero result not clean")
	// stalled output holds
	`FPA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled output changed")
	// no output right after reset release
	`FPA_ASSERT_NEXT(a_rst_quiet, clk, arst_n, $rose(arst_n), !out_valid, "output valid straight after reset")
endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_data (out_ch.data)
);
